@@ hw/rtl/sorted_priority_queue_core_macros.svh @@
// Assertion macros shared by the sorted priority queue RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/spq_pkg.sv @@
// Package for the sorted priority queue: sizes, operation and status codes,
// and the command and status structs between controller and datapath.
// Depends on nothing.
package spq_pkg;

  // Queue sizing.
  localparam int DEPTH         = 16;
  localparam int VALUE_BITS    = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int IDX_W         = $clog2(DEPTH);

  // Fixed field widths of the channels.
  localparam int OP_W     = 2;
  localparam int VAL_W    = 32;
  localparam int PRI_W    = 16;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_ENQ = 2'd0;
  localparam op_t OP_DEQ = 2'd1;
  localparam op_t OP_CLR = 2'd2;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_OVER  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch the incoming transaction
    logic exec;     // apply the operation to the queue
    logic capture;  // load the result register
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } spq_stat_t;

endpackage

@@ hw/rtl/spq_ifs.sv @@
// Channel interfaces of the sorted priority queue: request and result.
// Depends on spq_pkg.
interface spq_in_if;
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [VAL_W-1:0]    value;
  logic [PRI_W-1:0]    priority_req;

  modport source (output valid, operation, value, priority_req, input ready);
  modport sink   (input valid, operation, value, priority_req, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                front_valid;
  logic [VAL_W-1:0]    front_value;
  logic [PRI_W-1:0]    front_priority;
  logic [TOTAL_W-1:0]  entry_total;
  logic                is_full;

  modport source (output valid, status, front_valid, front_value, front_priority,
                  entry_total, is_full, input ready);
  modport sink   (input valid, status, front_valid, front_value, front_priority,
                  entry_total, is_full, output ready);
endinterface

@@ hw/rtl/spq_dpath.sv @@
// Datapath of the sorted priority queue: the sorted slot row with one
// comparator per slot, the entry count and the result register.
// Depends on spq_pkg and the assertion macro header.
`include "sorted_priority_queue_core_macros.svh"

module spq_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spq_pkg::spq_cmd_t            cmd_i,
  output spq_pkg::spq_stat_t           stat_o,
  input  spq_pkg::op_t                 in_operation_i,
  input  logic [spq_pkg::VAL_W-1:0]    in_value_i,
  input  logic [spq_pkg::PRI_W-1:0]    in_priority_i,
  output spq_pkg::status_t             res_status_o,
  output logic                         res_front_valid_o,
  output logic [spq_pkg::VAL_W-1:0]    res_front_value_o,
  output logic [spq_pkg::PRI_W-1:0]    res_front_priority_o,
  output logic [spq_pkg::TOTAL_W-1:0]  res_entry_total_o,
  output logic                         res_is_full_o
);
  import spq_pkg::*;

  // Latched transaction.
  op_t                     op_r;
  logic [VALUE_BITS-1:0]   val_r;
  logic [PRIORITY_BITS-1:0] pri_r;

  // Slot row, ascending priority, top entry at count_r - 1.
  logic [VALUE_BITS-1:0]    slot_val_r [DEPTH];
  logic [PRIORITY_BITS-1:0] slot_pri_r [DEPTH];
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  status_t                  status_r;
  status_t                  status_nxt;

  // Result register.
  status_t                  res_status_r;
  logic                     res_fv_r;
  logic [VAL_W-1:0]         res_val_r;
  logic [PRI_W-1:0]         res_pri_r;
  logic [TOTAL_W-1:0]       res_total_r;
  logic                     res_full_r;

  logic             is_empty;
  logic             is_full;
  logic             do_insert;
  logic [DEPTH-1:0] lt;
  logic [IDX_W-1:0] top_idx;

  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign do_insert = cmd_i.exec && (op_r == OP_ENQ) && !is_full;
  assign stat_o    = '{empty: is_empty, full: is_full};

  // Capture the incoming transaction, cast to the stored widths.
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r  <= in_operation_i;
      val_r <= VALUE_BITS'(in_value_i);
      pri_r <= PRIORITY_BITS'(in_priority_i);
    end
  end

  // Each occupied slot compares its priority with the new one. Because the
  // row is sorted, the set of lower slots is a prefix and its end is the
  // insert position. Equal priorities stay above, so the oldest leaves first.
  for (genvar k = 0; k < DEPTH; k++) begin : g_slot
    assign lt[k] = (CNT_W'(k) < count_r) && (slot_pri_r[k] < pri_r);

    if (k == 0) begin : g_bottom
      always_ff @(posedge clk) begin
        if (do_insert && !lt[k]) begin
          slot_val_r[k] <= val_r;
          slot_pri_r[k] <= pri_r;
        end
      end
    end else begin : g_upper
      // A slot at the insert position takes the new entry; above it, shift up.
      always_ff @(posedge clk) begin
        if (do_insert && !lt[k]) begin
          if (lt[k-1]) begin
            slot_val_r[k] <= val_r;
            slot_pri_r[k] <= pri_r;
          end else begin
            slot_val_r[k] <= slot_val_r[k-1];
            slot_pri_r[k] <= slot_pri_r[k-1];
          end
        end
      end
    end
  end

  // Count and status update for the operation.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    case (op_r)
      OP_ENQ: begin
        if (is_full) begin
          status_nxt = ST_OVER;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_CLR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd_i.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.exec) begin
      status_r <= status_nxt;
    end
  end

  // Result register: the top entry of the queue after the operation.
  assign top_idx = IDX_W'(count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      res_status_r <= status_r;
      res_fv_r     <= !is_empty;
      res_val_r    <= is_empty ? '0 : VAL_W'(slot_val_r[top_idx]);
      res_pri_r    <= is_empty ? '0 : PRI_W'(slot_pri_r[top_idx]);
      res_total_r  <= TOTAL_W'(count_r);
      res_full_r   <= is_full;
    end
  end

  assign res_status_o         = res_status_r;
  assign res_front_valid_o    = res_fv_r;
  assign res_front_value_o    = res_val_r;
  assign res_front_priority_o = res_pri_r;
  assign res_entry_total_o    = res_total_r;
  assign res_is_full_o        = res_full_r;

  // Checks on the count bookkeeping.
  `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count exceeds depth")
  `SPQ_ASSERT_NEXT(a_deq_dec, cmd_i.exec && (op_r == OP_DEQ) && !is_empty, count_r == $past(count_r) - CNT_W'(1), "dequeue did not decrement")
  `SPQ_ASSERT_NEXT(a_enq_full_hold, cmd_i.exec && (op_r == OP_ENQ) && is_full, (count_r == $past(count_r)) && (status_r == ST_OVER), "full enqueue changed queue")
  `SPQ_ASSERT_NEXT(a_clr_empty, cmd_i.exec && (op_r == OP_CLR), count_r == '0, "clear left entries")

endmodule

@@ hw/rtl/spq_ctrl.sv @@
// Controller of the sorted priority queue: sequences accept, execute and
// result capture, and owns both handshakes. Depends on spq_pkg and the macros.
`include "sorted_priority_queue_core_macros.svh"

module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spq_pkg::spq_cmd_t  cmd_o,
  input  spq_pkg::spq_stat_t stat_i
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEND
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_rdy_r;
  logic   in_rdy_nxt;
  logic   out_vld_r;
  logic   out_vld_nxt;
  logic   in_take;
  logic   slot_free;

  assign in_take   = in_valid_i && in_rdy_r;
  assign slot_free = !out_vld_r || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    in_rdy_nxt    = in_rdy_r;
    out_vld_nxt   = out_vld_r && !out_ready_i;
    cmd_o.load    = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.capture = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          cmd_o.load = 1'b1;
          in_rdy_nxt = 1'b0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_nxt  = S_SEND;
      end
      S_SEND: begin
        // Wait until the result register is free, then refill it.
        if (slot_free) begin
          cmd_o.capture = 1'b1;
          out_vld_nxt   = 1'b1;
          in_rdy_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_rdy_r  <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_rdy_r  <= in_rdy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_ready_o  = in_rdy_r;
  assign out_valid_o = out_vld_r;

  // Sequencing checks.
  `SPQ_ASSERT_NEXT(a_take_exec, in_take, state_r == S_EXEC, "accepted transaction not executed")
  `SPQ_ASSERT_NEXT(a_capture_valid, cmd_o.capture, out_vld_r && in_rdy_r, "captured result not offered")
  `SPQ_ASSERT_SAME(a_ready_idle, in_rdy_r, state_r == S_IDLE, "ready outside idle")
  `SPQ_ASSERT_SAME(a_stat_excl, 1'b1, !(stat_i.empty && stat_i.full), "queue both empty and full")

endmodule

@@ hw/rtl/sorted_priority_queue_core.sv @@
// Sorted priority queue of spq_pkg::DEPTH entries. Each request transaction
// (enqueue, dequeue of the highest priority, clear) yields one result that
// reports status and the queue's front, count and full flag afterwards. A
// transaction is latched on acceptance; then every slot compares its
// priority with the new one in parallel and the row shifts; then the result
// register is loaded, which waits while an earlier result is not yet taken.
// No new request is accepted until the result register has been loaded.
// Depends on spq_pkg, the channel interfaces, spq_ctrl and spq_dpath.
module sorted_priority_queue_core (
  input  logic             clk,
  input  logic             rst_n,
  spq_in_if.sink           in_ch,
  spq_out_if.source        out_ch
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  // Sequencing of the handshakes.
  spq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Queue storage and result register.
  spq_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .in_operation_i       (in_ch.operation),
    .in_value_i           (in_ch.value),
    .in_priority_i        (in_ch.priority_req),
    .res_status_o         (out_ch.status),
    .res_front_valid_o    (out_ch.front_valid),
    .res_front_value_o    (out_ch.front_value),
    .res_front_priority_o (out_ch.front_priority),
    .res_entry_total_o    (out_ch.entry_total),
    .res_is_full_o        (out_ch.is_full)
  );

endmodule
